FILE: hdl/stcl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo tremolo soft clip package
// Shared widths, reset values, fixed-point constants and register indexes.
// ============================================================================
package stcl_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int CLIP_TABLE_BITS_DEF = 10;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_PHASE_STEP = 2'd0;
    localparam t_cfg_index REG_MOD_DEPTH  = 2'd1;
    localparam t_cfg_index REG_WAVE_MIX   = 2'd2;

    localparam logic [31:0] PHASE_STEP_RST = 32'd447392;
    localparam logic [15:0] MOD_DEPTH_RST  = 16'd16384;
    localparam logic [15:0] WAVE_MIX_RST   = 16'd6554;

    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [15:0] SIN_A1    = 16'd51472;
    localparam logic [15:0] SIN_B3    = 16'd21024;
    localparam logic [15:0] SIN_C5    = 16'd2320;
    localparam logic [15:0] DRIVE_Q15 = 16'd34406;

    // Width of gain times drive, which stays below 2^31.
    localparam int GAIN_DRV_W = 31;

endpackage

FILE: hdl/stereo_tremolo_soft_clip_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo tremolo soft clip unit
// LFO tremolo with a sine to square blend and a table-based soft clip,
// computed on one shared multiplier under a small sequencer.
// ============================================================================
//
//  Channel   Direction  Handshake                      Word
//  s_axis    in         s_axis_tvalid / s_axis_tready  left_in, right_in
//  m_axis    out        m_axis_tvalid / m_axis_tready  left_out, right_out
//  cfg       in         i_cfg_wen, no back-pressure    phase_step, mod_depth, wave_mix
//
//  A word passes through the accept step, which also steps the phase, four multiplies
//  for the quarter sine, then eight steps per channel (shape, gain, drive, scale, two
//  clip table reads, interpolation, sign), all on the one multiplier. Input is taken
//  only while the sequencer is idle; a finished word waits in the output register, and
//  the sequencer holds in its last step while that is full.
//  Reset is synchronous and active low; it restores the register defaults and
//  clears the LFO phase.
//
module stereo_tremolo_soft_clip_unit #(
    parameter int SAMPLE_BITS     = stcl_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS      = stcl_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stcl_pkg::SINE_TABLE_BITS_DEF,
    parameter int CLIP_TABLE_BITS = stcl_pkg::CLIP_TABLE_BITS_DEF,
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  stcl_pkg::t_cfg_index             i_cfg_index,
    input  logic [stcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [TDATA_W-1:0]               s_axis_tdata,  // left_in, right_in
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [TDATA_W-1:0]               m_axis_tdata   // left_out, right_out
);
    import stcl_pkg::*;

    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int MUL_A_W    = SAMPLE_BITS;
    localparam int MUL_B_W    = GAIN_DRV_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int QTR_BITS   = SINE_TABLE_BITS - 2;
    localparam int X_SHIFT    = 17 - SINE_TABLE_BITS;
    localparam int CLIP_FB    = SAMPLE_BITS + 1 - CLIP_TABLE_BITS;
    localparam int CLIP_P     = 1 << (CLIP_TABLE_BITS - 2);
    localparam int IDX_W      = CLIP_TABLE_BITS - 1;
    localparam int CLIP_DEPTH = (1 << IDX_W) + 1;
    localparam int CLIP_AW    = CLIP_TABLE_BITS;
    localparam int SH_L       = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
    localparam int SH_R       = (FRAC_BITS >= 20) ? 0 : 20 - FRAC_BITS;
    localparam logic [63:0] FULL_SCALE = (64'd1 << FRAC_BITS) - 64'd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_T1    = 4'd2;
    localparam logic [3:0] S_T2    = 4'd3;
    localparam logic [3:0] S_Y     = 4'd4;
    localparam logic [3:0] S_SHAPE = 4'd5;
    localparam logic [3:0] S_GAIN  = 4'd6;
    localparam logic [3:0] S_DRV   = 4'd7;
    localparam logic [3:0] S_U     = 4'd8;
    localparam logic [3:0] S_RA    = 4'd9;
    localparam logic [3:0] S_RB    = 4'd10;
    localparam logic [3:0] S_INT   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic                   r_ch;
    logic [PHASE_BITS-1:0]  r_step;
    logic [15:0]            r_depth;
    logic [15:0]            r_mix;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [SAMPLE_BITS-1:0] r_mag_l;
    logic [SAMPLE_BITS-1:0] r_mag_r;
    logic                   r_neg_l;
    logic                   r_neg_r;
    logic [15:0]            r_x;
    logic [15:0]            r_x2;
    logic [15:0]            r_t;
    logic [14:0]            r_sin;
    logic [15:0]            r_shape;
    logic [15:0]            r_gain;
    logic [MUL_B_W-1:0]     r_g2;
    logic [SAMPLE_BITS-1:0] r_u;
    logic [FRAC_BITS-1:0]   r_rom;
    logic [FRAC_BITS-1:0]   r_a;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [SAMPLE_BITS-1:0] r_left;
    logic                   r_out_valid;
    logic [TDATA_W-1:0]     r_out_data;

    logic [FRAC_BITS-1:0]   w_clip [CLIP_DEPTH];

    // Soft clip curve x(27+x^2)/(27+9x^2), built at elaboration. Only about the lower half
    // of the drive range is reachable, since gain times drive stays below 1.06.
    for (genvar gi = 0; gi < CLIP_DEPTH; gi++) begin : g_clip
        localparam logic [63:0] PP  = 64'd27 * 64'(CLIP_P) * 64'(CLIP_P);
        localparam logic [63:0] NUM = 64'(gi) * (PP + 64'(gi) * 64'(gi));
        localparam logic [63:0] DEN = 64'(CLIP_P) * (PP + 64'd9 * 64'(gi) * 64'(gi));
        localparam logic [63:0] RAW = (NUM << 20) / DEN;
        localparam logic [63:0] SCL = (RAW << SH_L) >> SH_R;
        localparam logic [63:0] VAL = (gi >= 3 * CLIP_P) ? FULL_SCALE :
                                      ((SCL > FULL_SCALE) ? FULL_SCALE : SCL);
        assign w_clip[gi] = VAL[FRAC_BITS-1:0];
    end

    logic                       w_accept;
    logic                       w_out_free;
    logic [SAMPLE_BITS-1:0]     w_in_l;
    logic [SAMPLE_BITS-1:0]     w_in_r;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [14:0]                w_x_raw;
    logic [15:0]                w_x;
    logic                       w_s_neg;
    logic                       w_s_nonneg;
    logic [15:0]                w_su;
    logic [SAMPLE_BITS-1:0]     w_mag;
    logic                       w_neg;
    logic [IDX_W-1:0]           w_clip_idx;
    logic [CLIP_FB-1:0]         w_clip_f;
    logic [CLIP_AW-1:0]         w_clip_addr;
    logic [FRAC_BITS-1:0]       w_y;
    logic [SAMPLE_BITS-1:0]     w_y_ext;
    logic [SAMPLE_BITS-1:0]     w_res;
    logic [16:0]                w_y17;
    logic [MUL_A_W-1:0]         w_mul_a;
    logic [MUL_B_W-1:0]         w_mul_b;
    logic [MUL_P_W-1:0]         w_prod;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_in_l = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_in_r = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // The right channel sits half a turn away, which only flips the sine sign.
    assign w_idx      = r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign w_quad     = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_x_raw    = {w_idx[QTR_BITS-1:0], {X_SHIFT{1'b0}}};
    assign w_x        = w_quad[0] ? (ONE_Q15 - {1'b0, w_x_raw}) : {1'b0, w_x_raw};
    assign w_s_neg    = w_quad[1] ^ r_ch;
    assign w_s_nonneg = !w_s_neg || (r_sin == 15'd0);
    assign w_su       = w_s_neg ? (ONE_Q15 - {1'b0, r_sin}) : (ONE_Q15 + {1'b0, r_sin});

    assign w_mag = r_ch ? r_mag_r : r_mag_l;
    assign w_neg = r_ch ? r_neg_r : r_neg_l;

    assign w_clip_idx  = r_u[SAMPLE_BITS-1:CLIP_FB];
    assign w_clip_f    = r_u[CLIP_FB-1:0];
    assign w_clip_addr = (r_state == S_RB) ? ({1'b0, w_clip_idx} + CLIP_AW'(1))
                                           : {1'b0, w_clip_idx};

    assign w_y     = r_a + r_frac;
    assign w_y_ext = {1'b0, w_y};
    assign w_res   = w_neg ? (~w_y_ext + SAMPLE_BITS'(1)) : w_y_ext;
    assign w_y17   = w_prod[31:15];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ: begin
                w_mul_a = MUL_A_W'(w_x);
                w_mul_b = MUL_B_W'(w_x);
            end
            S_T1: begin
                w_mul_a = MUL_A_W'(SIN_C5);
                w_mul_b = MUL_B_W'(r_x2);
            end
            S_T2: begin
                w_mul_a = MUL_A_W'(r_t);
                w_mul_b = MUL_B_W'(r_x2);
            end
            S_Y: begin
                w_mul_a = MUL_A_W'(r_t);
                w_mul_b = MUL_B_W'(r_x);
            end
            S_SHAPE: begin
                w_mul_a = MUL_A_W'(w_su);
                w_mul_b = MUL_B_W'(ONE_Q15 - r_mix);
            end
            S_GAIN: begin
                w_mul_a = MUL_A_W'(r_depth);
                w_mul_b = MUL_B_W'(ONE_Q15 - r_shape);
            end
            S_DRV: begin
                w_mul_a = MUL_A_W'(r_gain);
                w_mul_b = MUL_B_W'(DRIVE_Q15);
            end
            S_U: begin
                w_mul_a = w_mag;
                w_mul_b = r_g2;
            end
            S_INT: begin
                w_mul_a = MUL_A_W'(r_rom - r_a);
                w_mul_b = MUL_B_W'(w_clip_f);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = s_axis_tvalid ? S_SQ : S_IDLE;
            S_SQ:    n_state = S_T1;
            S_T1:    n_state = S_T2;
            S_T2:    n_state = S_Y;
            S_Y:     n_state = S_SHAPE;
            S_SHAPE: n_state = S_GAIN;
            S_GAIN:  n_state = S_DRV;
            S_DRV:   n_state = S_U;
            S_U:     n_state = S_RA;
            S_RA:    n_state = S_RB;
            S_RB:    n_state = S_INT;
            S_INT:   n_state = S_FIN;
            S_FIN: begin
                if (!r_ch) begin
                    n_state = S_SHAPE;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 1'b0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= r_phase + r_step;
                r_ch    <= 1'b0;
            end else if (r_state == S_FIN && !r_ch) begin
                r_ch    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= PHASE_STEP_RST[PHASE_BITS-1:0];
            r_depth <= MOD_DEPTH_RST;
            r_mix   <= WAVE_MIX_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_PHASE_STEP: r_step  <= i_cfg_data[PHASE_BITS-1:0];
                REG_MOD_DEPTH:  r_depth <= (i_cfg_data[15:0] > ONE_Q15) ? ONE_Q15
                                                                        : i_cfg_data[15:0];
                REG_WAVE_MIX:   r_mix   <= (i_cfg_data[15:0] > ONE_Q15) ? ONE_Q15
                                                                        : i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg_l <= w_in_l[SAMPLE_BITS-1];
            r_neg_r <= w_in_r[SAMPLE_BITS-1];
            r_mag_l <= w_in_l[SAMPLE_BITS-1] ? (~w_in_l + SAMPLE_BITS'(1)) : w_in_l;
            r_mag_r <= w_in_r[SAMPLE_BITS-1] ? (~w_in_r + SAMPLE_BITS'(1)) : w_in_r;
        end
        case (r_state)
            S_SQ: begin
                r_x  <= w_x;
                r_x2 <= w_prod[30:15];
            end
            S_T1:    r_t     <= SIN_B3 - w_prod[30:15];
            S_T2:    r_t     <= SIN_A1 - w_prod[30:15];
            S_Y:     r_sin   <= (w_y17 > 17'd32767) ? 15'h7fff : w_y17[14:0];
            S_SHAPE: r_shape <= w_prod[31:16] + (w_s_nonneg ? r_mix : 16'd0);
            S_GAIN:  r_gain  <= ONE_Q15 - w_prod[30:15];
            S_DRV:   r_g2    <= w_prod[MUL_B_W-1:0];
            S_U:     r_u     <= w_prod[SAMPLE_BITS+29:30];
            S_RB:    r_a     <= r_rom;
            S_INT:   r_frac  <= w_prod[FRAC_BITS+CLIP_FB-1:CLIP_FB];
            S_FIN: begin
                if (!r_ch) begin
                    r_left <= w_res;
                end else if (w_out_free) begin
                    r_out_data <= TDATA_W'({w_res, r_left});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RA || r_state == S_RB) begin
            r_rom <= w_clip[w_clip_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && r_ch && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: hdl/stcl_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo tremolo soft clip checker
// Port-level assertions on handshake timing, bound to the top level.
// ============================================================================
module stcl_checker #(
    parameter int SAMPLE_BITS = stcl_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not cleared by reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while a word is in progress");

    a_result_with_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while the sequencer is still busy");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped before it was taken");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind stereo_tremolo_soft_clip_unit stcl_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_stcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/stcl_frame_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo tremolo soft clip frame checker
// Keeps its own copy of the registers and the LFO phase. For every stereo word
// taken in, it computes the tremolo gains and soft-clipped samples and queues
// the samples. Every word sent out is compared field by field with the oldest
// queued word.
// ============================================================================
module stcl_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  stcl_pkg::t_cfg_index            i_cfg_index,
    input  logic [stcl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [47:0]                     s_axis_tdata,  // left_in, right_in
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [47:0]                     m_axis_tdata,  // left_out, right_out
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);
    import stcl_pkg::*;

    typedef longint unsigned u64_t;
    typedef logic [23:0] sample_t;
    typedef struct packed {
        sample_t right;
        sample_t left;
    } frame_t;

    localparam u64_t UNITY       = 64'd32768;
    localparam u64_t POLY_A      = 64'd51472;
    localparam u64_t POLY_B      = 64'd21024;
    localparam u64_t POLY_C      = 64'd2320;
    localparam u64_t DRIVE_GAIN  = 64'd34406;
    localparam u64_t FULL_SCALE  = 64'd8388607;
    localparam u64_t CURVE_QUART = 64'd256;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    logic [31:0] step_reg;
    logic [15:0] depth_reg;
    logic [15:0] mix_reg;
    logic [31:0] lfo_phase;
    frame_t      predicted_frames[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic u64_t quarter_sine(input u64_t x);
        u64_t x2, t, y;
        x2 = (x * x) >> 15;
        t  = POLY_B - ((POLY_C * x2) >> 15);
        t  = POLY_A - ((t * x2) >> 15);
        y  = (t * x) >> 15;
        return (y > 64'd32767) ? 64'd32767 : y;
    endfunction

    function automatic int sine_of(input logic [9:0] idx);
        u64_t x;
        int   y;
        x = u64_t'(idx[7:0]) << 7;
        if (idx[8]) begin
            x = UNITY - x;
        end
        y = int'(quarter_sine(x));
        return idx[9] ? -y : y;
    endfunction

    function automatic u64_t tremolo_gain(input logic [31:0] phase, input u64_t mix,
                                          input u64_t depth);
        int   s;
        u64_t lifted, square, shape;
        s      = sine_of(phase[31:22]);
        lifted = u64_t'(s + 32768);
        square = (s >= 0) ? 64'd65536 : 64'd0;
        shape  = (lifted * (UNITY - mix) + square * mix) >> 16;
        return UNITY - ((depth * (UNITY - shape)) >> 15);
    endfunction

    function automatic u64_t clip_curve(input u64_t i);
        u64_t num, den, v;
        if (i >= 3 * CURVE_QUART) begin
            return FULL_SCALE;
        end
        num = i * (27 * CURVE_QUART * CURVE_QUART + i * i);
        den = CURVE_QUART * (27 * CURVE_QUART * CURVE_QUART + 9 * i * i);
        v   = ((num << 20) / den) << 3;
        return (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

    function automatic u64_t clip_magnitude(input u64_t mag, input u64_t gain);
        u64_t drive, i, f, a, b;
        drive = (mag * gain * DRIVE_GAIN) >> 30;
        i     = drive >> 15;
        if (i >= 64'd1024) begin
            return FULL_SCALE;
        end
        f = drive & 64'd32767;
        a = clip_curve(i);
        b = clip_curve(i + 1);
        return a + (((b - a) * f) >> 15);
    endfunction

    function automatic sample_t shape_sample(input sample_t raw, input u64_t gain);
        u64_t mag, y;
        mag = raw[23] ? ((64'd1 << 24) - u64_t'(raw)) : u64_t'(raw);
        y   = clip_magnitude(mag, gain);
        return raw[23] ? sample_t'(64'd0 - y) : sample_t'(y);
    endfunction

    task automatic report_field(input string name, input sample_t want, input sample_t got);
        o_errors++;
        if (o_errors <= 10) begin
            $display("mismatch on word %0d, %s: expected %h, got %h",
                     o_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        frame_t in_frame, out_frame, want;
        u64_t   depth_sat, mix_sat, gain_l, gain_r;
        if (!i_rst_n) begin
            step_reg  = 32'd447392;
            depth_reg = 16'd16384;
            mix_reg   = 16'd6554;
            lfo_phase = '0;
            predicted_frames.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    REG_PHASE_STEP: step_reg  = i_cfg_data;
                    REG_MOD_DEPTH:  depth_reg = i_cfg_data[15:0];
                    REG_WAVE_MIX:   mix_reg   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_frame   = frame_t'(s_axis_tdata);
                depth_sat  = (u64_t'(depth_reg) > UNITY) ? UNITY : u64_t'(depth_reg);
                mix_sat    = (u64_t'(mix_reg) > UNITY) ? UNITY : u64_t'(mix_reg);
                lfo_phase  = lfo_phase + step_reg;
                gain_l     = tremolo_gain(lfo_phase, mix_sat, depth_sat);
                gain_r     = tremolo_gain(lfo_phase + HALF_TURN, mix_sat, depth_sat);
                want.left  = shape_sample(in_frame.left, gain_l);
                want.right = shape_sample(in_frame.right, gain_r);
                predicted_frames.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_frame = frame_t'(m_axis_tdata);
                if (predicted_frames.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected output word %h", m_axis_tdata);
                    end
                end else begin
                    want = predicted_frames.pop_front();
                    if (out_frame.left !== want.left) begin
                        report_field("left", want.left, out_frame.left);
                    end
                    if (out_frame.right !== want.right) begin
                        report_field("right", want.right, out_frame.right);
                    end
                    o_checked++;
                end
            end
        end
        o_pending = predicted_frames.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Stereo tremolo soft clip testbench
// Drives stereo words with random gaps and output stalls through a series of
// register settings, directed extremes first and random words after, and
// leaves checking of the output words to the frame checker.
// ============================================================================
module testbench;
    import stcl_pkg::*;

    typedef logic [23:0] sample_t;

    localparam int      TDATA_W       = ((2 * 24 + 7) / 8) * 8;
    localparam int      SETTLE_CYCLES = 24;
    localparam int      LONG_HOLD     = 300;
    localparam int      PHASE_WORDS   = 250;
    localparam sample_t MAX_POS       = 24'h7F_FFFF;
    localparam sample_t MIN_NEG       = 24'h80_0000;
    localparam sample_t MINUS_ONE     = 24'hFF_FFFF;
    localparam t_cfg_index REG_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    t_cfg_index            i_cfg_index = REG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;  // left_in, right_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;       // left_out, right_out

    int errors, pending, checked;
    bit idle_mode = 1'b1;
    bit long_hold = 1'b0;
    int settings_loaded = 0;

    stereo_tremolo_soft_clip_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stcl_frame_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic cfg_write(input t_cfg_index idx, input logic [31:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] step, input logic [15:0] depth,
                                 input logic [15:0] mix);
        cfg_write(REG_PHASE_STEP, step);
        cfg_write(REG_MOD_DEPTH, {16'($urandom), depth});
        cfg_write(REG_WAVE_MIX, {16'($urandom), mix});
        i_cfg_wen <= 1'b0;
        settings_loaded++;
    endtask

    task automatic send_frame(input sample_t left, input sample_t right);
        int   gap;
        logic took;
        gap = idle_mode ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? MAX_POS : MIN_NEG;
            1: return sample_t'($urandom_range(0, 8191)) - sample_t'(4096);
            2: return sample_t'(signed'(20'($urandom)));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Output side: random stalls per word, plus one long hold-off on request.
    initial begin
        int   gap;
        logic got;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = idle_mode ? $urandom_range(0, 11) : 0;
            if (long_hold) begin
                gap       = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                got = m_axis_tvalid;
                @(posedge i_clk);
            end while (!got);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values, full-scale and sign-boundary samples.
        send_frame(24'h00_0000, 24'h00_0000);
        send_frame(MAX_POS, MIN_NEG);
        send_frame(MIN_NEG, MAX_POS);
        send_frame(MINUS_ONE, 24'h00_0001);
        send_frame(MAX_POS, MAX_POS);
        send_frame(MIN_NEG, MIN_NEG);
        send_frame(24'h40_0000, 24'hC0_0000);
        send_frame(24'h12_3456, 24'hED_CBA9);
        drain();

        // Frozen phase at zero: the sine is zero and counts as positive.
        load_settings(32'd0, 16'd32768, 16'd32768);
        send_frame(MAX_POS, MIN_NEG);
        send_frame(24'h20_0000, 24'hE0_0000);
        send_frame(24'h00_0000, MINUS_ONE);
        send_frame(24'h55_5555, 24'hAA_AAAA);
        drain();

        // Half-turn steps with depth and mix above one.
        load_settings(32'h8000_0000, 16'hFFFF, 16'd40000);
        send_frame(MAX_POS, MIN_NEG);
        send_frame(24'h30_0000, 24'hD0_0000);
        send_frame(24'h00_0001, MINUS_ONE);
        send_frame(24'h0F_FFFF, 24'hF0_0001);
        drain();

        // A write to the unused index must change nothing.
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        load_settings(32'h4000_0000, 16'd0, 16'd0);
        send_frame(MAX_POS, MIN_NEG);
        send_frame(24'h60_0000, 24'hA0_0000);
        send_frame(MAX_POS, MAX_POS);
        send_frame(MIN_NEG, MIN_NEG);
        send_frame(24'h00_00FF, 24'hFF_FF00);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_settings(32'hFFFF_FFFF, 16'd32768, 16'd0);
                1: load_settings(32'($urandom_range(1, 1 << 24)),
                                 16'($urandom_range(0, 32768)),
                                 16'($urandom_range(0, 32768)));
                2: load_settings($urandom, 16'd32768, 16'd32768);
                3: load_settings(32'd447392, 16'd16384, 16'd6554);
                default: load_settings($urandom, 16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)));
            endcase
            idle_mode = (p % 3 != 2);
            if (p == 1) begin
                long_hold = 1'b1;
            end
            repeat (PHASE_WORDS) send_frame(random_sample(), random_sample());
            drain();
        end

        $display("Checked %0d stereo words under %0d register settings.",
                 checked, settings_loaded);
        $display("Included full-scale samples, frozen and half-turn phases, "
                 , "saturated depth and mix, idle-free bursts and a long output stall.");
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
